### sv/ow_pkg.sv
// ----------------------------------------------------------------------------
// ow_pkg - shared types and constants of the one-wire bus master
// Timing register layout, command codes and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package ow_pkg;

  localparam int unsigned TICK_W = 10;

  // command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // timing register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_WRITE_LOW     = 3'd3;
  localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
  localparam logic [2:0] REG_READ_LOW      = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_READ_RECOVERY = 3'd7;

  // reset values, in ticks
  localparam logic [TICK_W-1:0] RST_RESET_LOW     = 10'd500;
  localparam logic [TICK_W-1:0] RST_PRESENCE_WAIT = 10'd55;
  localparam logic [TICK_W-1:0] RST_RESET_TAIL    = 10'd400;
  localparam logic [TICK_W-1:0] RST_WRITE_LOW     = 10'd8;
  localparam logic [TICK_W-1:0] RST_WRITE_HOLD    = 10'd100;
  localparam logic [TICK_W-1:0] RST_READ_LOW      = 10'd4;
  localparam logic [TICK_W-1:0] RST_READ_SAMPLE   = 10'd15;
  localparam logic [TICK_W-1:0] RST_READ_RECOVERY = 10'd70;

  typedef struct packed {
    logic [TICK_W-1:0] reset_low;
    logic [TICK_W-1:0] presence_wait;
    logic [TICK_W-1:0] reset_tail;
    logic [TICK_W-1:0] write_low;
    logic [TICK_W-1:0] write_hold;
    logic [TICK_W-1:0] read_low;
    logic [TICK_W-1:0] read_sample;
    logic [TICK_W-1:0] read_recovery;
  } ow_cfg_t;

  // result word, drive_low in the lowest bit
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       device_present;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } ow_res_t;

endpackage

`default_nettype wire

### sv/ow_engine.sv
// ----------------------------------------------------------------------------
// ow_engine - slot sequencer of the one-wire bus master
// Advances the phase machine by one tick per step and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ow_engine
  import ow_pkg::*;
#(
  parameter int unsigned BYTE_GAP_TICKS = 50
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ow_cfg_t    cfg,
  input  wire logic       step,
  input  wire logic [1:0] command,
  input  wire logic [7:0] tx_byte,
  input  wire logic       line_in,
  output ow_res_t         res
);

  localparam logic [TICK_W-1:0] GAP = TICK_W'(BYTE_GAP_TICKS);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL,
    PH_WR_LOW, PH_WR_HOLD, PH_WR_GAP,
    PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
  } phase_t;

  phase_t            phase, phase_next;
  logic [TICK_W-1:0] tick_count, tick_next;
  logic [2:0]        bit_index, bit_next;
  logic [7:0]        shift_byte, shift_next;
  logic              presence_seen, presence_next;
  ow_res_t           res_next;

  logic [TICK_W-1:0] len;
  logic [TICK_W-1:0] tick_inc;
  logic              over;

  // length of the current phase
  always_comb begin
    case (phase)
      PH_RST_LOW:  len = cfg.reset_low;
      PH_RST_WAIT: len = cfg.presence_wait;
      PH_RST_TAIL: len = cfg.reset_tail;
      PH_WR_LOW:   len = cfg.write_low;
      PH_WR_HOLD:  len = cfg.write_hold;
      PH_WR_GAP:   len = GAP;
      PH_RD_LOW:   len = cfg.read_low;
      PH_RD_WAIT:  len = cfg.read_sample;
      PH_RD_REC:   len = cfg.read_recovery;
      default:     len = '0;
    endcase
  end

  assign tick_inc = tick_count + TICK_W'(1);
  // a zero length ends on the first tick
  assign over     = (tick_inc >= len);

  always_comb begin
    phase_next    = phase;
    tick_next     = over ? '0 : tick_inc;
    bit_next      = bit_index;
    shift_next    = shift_byte;
    presence_next = presence_seen;
    res_next      = '0;

    case (phase)
      PH_IDLE: begin
        tick_next = '0;
        if (command != CMD_NONE) begin
          bit_next      = '0;
          presence_next = 1'b0;
          shift_next    = (command == CMD_WRITE) ? tx_byte : 8'd0;
          case (command)
            CMD_RESET: phase_next = PH_RST_LOW;
            CMD_WRITE: phase_next = PH_WR_LOW;
            default:   phase_next = PH_RD_LOW;
          endcase
        end
      end
      PH_RST_LOW: begin
        if (over) phase_next = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (over) begin
          presence_next = ~line_in;
          phase_next    = PH_RST_TAIL;
        end
      end
      PH_RST_TAIL: begin
        if (over) begin
          res_next.device_present = presence_seen & line_in;
          res_next.done_res       = 1'b1;
          phase_next              = PH_IDLE;
        end
      end
      PH_WR_LOW: begin
        if (over) phase_next = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        if (over) begin
          bit_next = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            if (GAP == '0) begin
              res_next.done_res = 1'b1;
              phase_next        = PH_IDLE;
            end else begin
              phase_next = PH_WR_GAP;
            end
          end else begin
            phase_next = PH_WR_LOW;
          end
        end
      end
      PH_WR_GAP: begin
        if (over) begin
          res_next.done_res = 1'b1;
          phase_next        = PH_IDLE;
        end
      end
      PH_RD_LOW: begin
        if (over) phase_next = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        if (over) begin
          shift_next[bit_index] = shift_byte[bit_index] | line_in;
          phase_next            = PH_RD_REC;
        end
      end
      PH_RD_REC: begin
        if (over) begin
          bit_next = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            res_next.rx_byte  = shift_byte;
            res_next.done_res = 1'b1;
            phase_next        = PH_IDLE;
          end else begin
            phase_next = PH_RD_LOW;
          end
        end
      end
      default: begin
        tick_next  = '0;
        phase_next = PH_IDLE;
      end
    endcase

    // line drive follows the phase after this tick
    case (phase_next)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res_next.drive_low = 1'b1;
      PH_WR_HOLD: res_next.drive_low = ~shift_next[bit_next];
      default:    res_next.drive_low = 1'b0;
    endcase
    res_next.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_seen <= 1'b0;
      res           <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_next;
      bit_index     <= bit_next;
      shift_byte    <= shift_next;
      presence_seen <= presence_next;
      res           <= res_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> !res.busy_res)
    else $error("done word still shows busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    res.drive_low |-> res.busy_res)
    else $error("line driven while idle");

  a_present_done: assert property (@(posedge clk) disable iff (rst)
    res.device_present |-> res.done_res)
    else $error("presence reported without done");

  a_start: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && command != CMD_NONE |=> res.busy_res && res.drive_low)
    else $error("command did not start a slot");

  a_rx_done: assert property (@(posedge clk) disable iff (rst)
    res.rx_byte != 8'd0 |-> res.done_res)
    else $error("read byte shown without done");

endmodule

`default_nettype wire

### sv/one_wire_bus_master_top.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_top - one-wire bus master, stepped once per timer tick
// Stream wrapper with the timing registers and the result word register.
// ----------------------------------------------------------------------------
// Each input word is one timer tick: it carries the command (acted on only
// while idle), the byte to send and the line level sampled on that tick. Every
// accepted word yields exactly one result word with the line drive, busy, done,
// presence and read byte after that tick. One word is taken per clock cycle;
// the cycle holds the phase machine's single length compare and next-state
// logic, and the result word register lets a new tick enter in the same cycle
// that the previous result is taken. If the result side stalls, the input side
// stalls with it. A reset pulse, a byte write and a byte read run as timed phases
// whose lengths come from eight 10-bit timing registers (a zero length counts
// as one tick); the gap after a written byte is BYTE_GAP_TICKS (0 skips it).
// Timing registers are written via cfg_we/cfg_index/cfg_data only while idle; the user ensures it, not the block.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_top
  import ow_pkg::*;
#(
  parameter int unsigned BYTE_GAP_TICKS = 50
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // tdata: command[1:0], tx_byte[9:2], line_in[10], zero fill
  input  wire logic [15:0]       s_tdata,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // tdata: drive_low[0], busy_res[1], done_res[2], device_present[3],
  //        rx_byte[11:4], zero fill
  output logic [15:0]            m_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [TICK_W-1:0] cfg_data
);

  ow_cfg_t cfg;
  ow_res_t res;
  logic    accept;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low     <= RST_RESET_LOW;
      cfg.presence_wait <= RST_PRESENCE_WAIT;
      cfg.reset_tail    <= RST_RESET_TAIL;
      cfg.write_low     <= RST_WRITE_LOW;
      cfg.write_hold    <= RST_WRITE_HOLD;
      cfg.read_low      <= RST_READ_LOW;
      cfg.read_sample   <= RST_READ_SAMPLE;
      cfg.read_recovery <= RST_READ_RECOVERY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:     cfg.reset_low     <= cfg_data;
        REG_PRESENCE_WAIT: cfg.presence_wait <= cfg_data;
        REG_RESET_TAIL:    cfg.reset_tail    <= cfg_data;
        REG_WRITE_LOW:     cfg.write_low     <= cfg_data;
        REG_WRITE_HOLD:    cfg.write_hold    <= cfg_data;
        REG_READ_LOW:      cfg.read_low      <= cfg_data;
        REG_READ_SAMPLE:   cfg.read_sample   <= cfg_data;
        REG_READ_RECOVERY: cfg.read_recovery <= cfg_data;
        default: ;
      endcase
    end
  end

  // a tick is taken whenever the result register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= accept || (m_tvalid && !m_tready);
    end
  end

  ow_engine #(
    .BYTE_GAP_TICKS(BYTE_GAP_TICKS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (accept),
    .command (s_tdata[1:0]),
    .tx_byte (s_tdata[9:2]),
    .line_in (s_tdata[10]),
    .res     (res)
  );

  assign m_tdata = {4'b0000, res};

endmodule

`default_nettype wire

### tb/one_wire_bus_master_top_tb.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_top_tb - self-checking bench for the one-wire master
// Feeds timer-tick words (command, byte to send, line level) and checks every
// result word against a tick-exact model of the slot timing kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_top_tb;
  import ow_pkg::*;

  localparam int unsigned GAP_TICKS = 50;
  localparam int LONG_HOLD = 300;    // receiver hold-off used to back up the input
  localparam int WDOG_LIMIT = 4000;  // cycles with nothing moving while work is pending
  localparam int TAIL_CYCLES = 4;    // result register plus margin
  localparam int MODE_TICKS = 140;   // tick words per random mode, at least

  // one input word; last field in the lowest bits
  typedef struct packed {
    logic       line;
    logic [7:0] tx;
    logic [1:0] cmd;
  } tick_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL,
    PH_WR_LOW, PH_WR_HOLD, PH_WR_GAP,
    PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
  } bus_phase_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [TICK_W-1:0] cfg_data = '0;

  one_wire_bus_master_top #(
    .BYTE_GAP_TICKS(GAP_TICKS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  tick_t   tick_q[$];      // words waiting to be offered
  ow_res_t line_exp_q[$];  // predicted result words, oldest first

  int idle_pct = 0;   // sender: chance per cycle of not offering a word
  int stall_pct = 0;  // receiver: chance per cycle of tready low
  int hold_req = 0;   // bumped by the stimulus to ask for one long hold-off

  int errors = 0;
  int n_checked = 0;
  int n_pushed = 0;
  int n_cfg = 0;
  int n_rst_done = 0, n_present = 0, n_wr_done = 0, n_rd_done = 0;

  // bench copy of the timing registers and of the phase machine
  logic [TICK_W-1:0] timing [8];
  bus_phase_t  bus_ph = PH_IDLE;
  logic [1:0]  bus_op = CMD_NONE;
  logic [9:0]  tick_cnt = '0;
  logic [2:0]  bit_idx = '0;
  logic [7:0]  shift_q = '0;
  logic        pres_seen = 1'b0;

  // ---------------------------------------------------------------------------
  // Slot timing model
  // ---------------------------------------------------------------------------
  function automatic void enter_phase(input bus_phase_t p);
    bus_ph = p;
    tick_cnt = '0;
  endfunction

  // counts one tick; true on the last tick of a phase of len ticks
  function automatic logic phase_end(input logic [9:0] len);
    tick_cnt = tick_cnt + 10'd1;
    if (tick_cnt >= len) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic ow_res_t step_bus(input tick_t t);
    ow_res_t r;
    logic       done;
    logic       pres;
    logic [7:0] rxb;
    done = 1'b0;
    pres = 1'b0;
    rxb = '0;
    case (bus_ph)
      PH_IDLE: begin
        // commands are only taken here; anything sent while busy is dropped
        if (t.cmd != CMD_NONE) begin
          bus_op = t.cmd;
          bit_idx = '0;
          pres_seen = 1'b0;
          shift_q = (t.cmd == CMD_WRITE) ? t.tx : 8'h00;
          if (t.cmd == CMD_RESET) enter_phase(PH_RST_LOW);
          else if (t.cmd == CMD_WRITE) enter_phase(PH_WR_LOW);
          else enter_phase(PH_RD_LOW);
        end
      end
      PH_RST_LOW: if (phase_end(timing[REG_RESET_LOW])) enter_phase(PH_RST_WAIT);
      PH_RST_WAIT: begin
        if (phase_end(timing[REG_PRESENCE_WAIT])) begin
          pres_seen = ~t.line;
          enter_phase(PH_RST_TAIL);
        end
      end
      PH_RST_TAIL: begin
        // present only for low at the first sample and high at the second
        if (phase_end(timing[REG_RESET_TAIL])) begin
          pres = pres_seen & t.line;
          done = 1'b1;
          enter_phase(PH_IDLE);
        end
      end
      PH_WR_LOW: if (phase_end(timing[REG_WRITE_LOW])) enter_phase(PH_WR_HOLD);
      PH_WR_HOLD: begin
        if (phase_end(timing[REG_WRITE_HOLD])) begin
          if (bit_idx == 3'd7) begin
            bit_idx = '0;
            if (GAP_TICKS == 0) begin
              done = 1'b1;
              enter_phase(PH_IDLE);
            end else begin
              enter_phase(PH_WR_GAP);
            end
          end else begin
            bit_idx = bit_idx + 3'd1;
            enter_phase(PH_WR_LOW);
          end
        end
      end
      PH_WR_GAP: begin
        if (phase_end(10'(GAP_TICKS))) begin
          done = 1'b1;
          enter_phase(PH_IDLE);
        end
      end
      PH_RD_LOW: if (phase_end(timing[REG_READ_LOW])) enter_phase(PH_RD_WAIT);
      PH_RD_WAIT: begin
        if (phase_end(timing[REG_READ_SAMPLE])) begin
          shift_q = shift_q | (8'(t.line) << bit_idx);
          enter_phase(PH_RD_REC);
        end
      end
      PH_RD_REC: begin
        if (phase_end(timing[REG_READ_RECOVERY])) begin
          if (bit_idx == 3'd7) begin
            bit_idx = '0;
            rxb = shift_q;
            done = 1'b1;
            enter_phase(PH_IDLE);
          end else begin
            bit_idx = bit_idx + 3'd1;
            enter_phase(PH_RD_LOW);
          end
        end
      end
      default: enter_phase(PH_IDLE);
    endcase

    if (done) begin
      case (bus_op)
        CMD_RESET: begin
          n_rst_done++;
          if (pres) n_present++;
        end
        CMD_WRITE: n_wr_done++;
        default: n_rd_done++;
      endcase
    end

    r = '0;
    if (bus_ph inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW}) r.drive_low = 1'b1;
    else if (bus_ph == PH_WR_HOLD) r.drive_low = ~shift_q[bit_idx];
    r.busy_res = (bus_ph != PH_IDLE);
    r.done_res = done;
    r.device_present = pres;
    r.rx_byte = rxb;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers queued words, predicts each accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drv
    tick_t cur;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) line_exp_q.push_back(step_bus(tick_t'(s_tdata[10:0])));
      // a held word stays put until taken; otherwise pick the next or go quiet
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur = tick_q.pop_front();
          s_tdata <= {5'b0, cur};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off on request, checks
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int hold_ack = 0;

  always @(posedge clk) begin : mon
    ow_res_t got;
    ow_res_t want;
    logic    rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = ow_res_t'(m_tdata[$bits(ow_res_t)-1:0]);
        if (line_exp_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result word: drive=%b busy=%b done=%b pres=%b rx=%02h",
                     got.drive_low, got.busy_res, got.done_res, got.device_present,
                     got.rx_byte);
        end else begin
          want = line_exp_q.pop_front();
          if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res ||
              got.device_present !== want.device_present ||
              got.rx_byte !== want.rx_byte) begin
            errors++;
            if (errors <= 10) begin
              $display("ERROR: word %0d: exp drive=%b busy=%b done=%b pres=%b rx=%02h",
                       n_checked, want.drive_low, want.busy_res, want.done_res,
                       want.device_present, want.rx_byte);
              $display("       got drive=%b busy=%b done=%b pres=%b rx=%02h",
                       got.drive_low, got.busy_res, got.done_res, got.device_present,
                       got.rx_byte);
            end
          end
          n_checked++;
        end
      end

      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = LONG_HOLD;
        rdy = 1'b0;
      end else begin
        rdy = ($urandom_range(99) >= stall_pct);
      end
      m_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: nothing moving while words are pending or expected
  // ---------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (tick_q.size() == 0 && line_exp_q.size() == 0 && !s_tvalid)) begin
      quiet <= 0;
    end else if (quiet >= WDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles, %0d results outstanding",
               WDOG_LIMIT, line_exp_q.size());
      $display("one_wire_bus_master_top_tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int span(input logic [2:0] idx);
    return (timing[idx] == 0) ? 1 : int'(timing[idx]);
  endfunction

  function automatic void push_tick(input logic [1:0] cmd, input logic [7:0] tx,
                                    input logic line);
    tick_t t;
    t.cmd = cmd;
    t.tx = tx;
    t.line = line;
    tick_q.push_back(t);
    n_pushed++;
  endfunction

  // tick during an operation; a command here must be ignored
  function automatic void push_busy(input logic line, input bit noisy);
    logic [1:0] c;
    c = CMD_NONE;
    if (noisy) c = 2'($urandom_range(3, 1));
    else if ($urandom_range(3) == 0) c = 2'($urandom_range(3));
    push_tick(c, 8'($urandom), line);
  endfunction

  function automatic void push_idle();
    push_tick(CMD_NONE, 8'($urandom), 1'($urandom));
  endfunction

  // reset pulse; s1/s2 are the line levels at the presence and final samples
  function automatic void run_reset(input logic s1, input logic s2, input bit noisy);
    int n1, n;
    n1 = span(REG_RESET_LOW) + span(REG_PRESENCE_WAIT);
    n = n1 + span(REG_RESET_TAIL);
    push_tick(CMD_RESET, 8'($urandom), 1'($urandom));
    for (int k = 1; k <= n; k++)
      push_busy((k == n1) ? s1 : (k == n) ? s2 : 1'($urandom), noisy);
  endfunction

  function automatic void run_write(input logic [7:0] b, input bit noisy);
    int n;
    n = 8 * (span(REG_WRITE_LOW) + span(REG_WRITE_HOLD)) + int'(GAP_TICKS);
    push_tick(CMD_WRITE, b, 1'($urandom));
    for (int k = 1; k <= n; k++) push_busy(1'($urandom), noisy);
  endfunction

  // read slot; the line carries b at each sample tick, noise elsewhere
  function automatic void run_read(input logic [7:0] b, input bit noisy);
    int slot, smp;
    slot = span(REG_READ_LOW) + span(REG_READ_SAMPLE) + span(REG_READ_RECOVERY);
    smp = span(REG_READ_LOW) + span(REG_READ_SAMPLE);
    push_tick(CMD_READ, 8'($urandom), 1'($urandom));
    for (int k = 0; k < 8 * slot; k++)
      push_busy(((k % slot) + 1 == smp) ? b[k / slot] : 1'($urandom), noisy);
  endfunction

  // wait until every word is through and the phase machine is back to idle
  task automatic settle();
    forever begin
      do @(negedge clk);
      while (tick_q.size() != 0 || line_exp_q.size() != 0 || s_tvalid);
      if (bus_ph == PH_IDLE) break;
      repeat (8) push_idle();
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [TICK_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    timing[idx] = val;
    n_cfg++;
  endtask

  task automatic close_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timing_all(input logic [TICK_W-1:0] val);
    settle();
    for (int i = 0; i < 8; i++) write_reg(3'(i), val);
    close_cfg();
  endtask

  // short slots mostly, so that many operations finish per mode
  task automatic set_timing_random();
    logic [TICK_W-1:0] v;
    settle();
    for (int i = 0; i < 8; i++) begin
      v = ($urandom_range(9) == 0) ? 10'($urandom_range(12, 5)) : 10'($urandom_range(4, 1));
      write_reg(3'(i), v);
    end
    close_cfg();
  endtask

  task automatic run_random_mode(input int idle, input int stall, input bit long_hold);
    int start;
    int n_ops;
    settle();
    idle_pct = idle;
    stall_pct = stall;
    start = n_pushed;
    while (n_pushed - start < MODE_TICKS) begin
      set_timing_random();
      if (long_hold) begin
        // queue is full and the sender keeps offering during the hold-off
        hold_req++;
        long_hold = 1'b0;
      end
      n_ops = $urandom_range(6, 3);
      for (int k = 0; k < n_ops && n_pushed - start < MODE_TICKS; k++) begin
        repeat ($urandom_range(3)) push_idle();
        case ($urandom_range(3, 1))
          1: run_reset(1'($urandom), 1'($urandom), 1'b0);
          2: run_write(8'($urandom), 1'b0);
          default: run_read(8'($urandom), 1'b0);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    timing[REG_RESET_LOW]     = RST_RESET_LOW;
    timing[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
    timing[REG_RESET_TAIL]    = RST_RESET_TAIL;
    timing[REG_WRITE_LOW]     = RST_WRITE_LOW;
    timing[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
    timing[REG_READ_LOW]      = RST_READ_LOW;
    timing[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
    timing[REG_READ_RECOVERY] = RST_READ_RECOVERY;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, shortest slots: idle words, every presence outcome, byte extremes
    set_timing_all(10'd1);
    push_tick(CMD_NONE, 8'hFF, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b0);
    run_reset(1'b0, 1'b1, 1'b0);
    run_reset(1'b1, 1'b1, 1'b1);
    run_reset(1'b0, 1'b0, 1'b0);
    run_reset(1'b1, 1'b0, 1'b0);
    run_write(8'h00, 1'b0);
    run_write(8'hFF, 1'b1);   // commands on every busy tick, done tick included
    run_read(8'hA5, 1'b1);
    run_read(8'hFF, 1'b0);
    run_read(8'h00, 1'b0);

    // zero lengths count as one tick
    set_timing_all(10'd0);
    run_reset(1'b0, 1'b1, 1'b0);
    run_write(8'h3C, 1'b0);
    run_read(8'hC3, 1'b0);

    // random traffic under each flow-control mix
    run_random_mode(0, 0, 1'b1);
    run_random_mode(77, 0, 1'b0);
    run_random_mode(0, 77, 1'b0);
    run_random_mode(31, 31, 1'b0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d tick words over %0d timing register writes.", n_checked, n_cfg);
    $display("Completed %0d resets (%0d with presence), %0d byte writes, %0d byte reads.",
             n_rst_done, n_present, n_wr_done, n_rd_done);
    if (errors == 0 && line_exp_q.size() == 0) begin
      $display("one_wire_bus_master_top_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, line_exp_q.size());
      $display("one_wire_bus_master_top_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
